// ----- sv/tcp_connection_tracker_top_defines.svh -----
// Assertion macros used by the connection tracker controller.
`ifndef TCP_CONNECTION_TRACKER_TOP_DEFINES_SVH
`define TCP_CONNECTION_TRACKER_TOP_DEFINES_SVH
// Same-cycle implication checked on every clock edge outside reset.
`define TCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tracker assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define TCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tracker assertion failed");
`endif

// ----- sv/tct_pkg.sv -----
// Package with types and constants of the TCP connection tracker.
`timescale 1ns / 1ps
`default_nettype none
package tct_pkg;
  localparam int MAX_CONNS = 64;
  localparam int IDX_W = $clog2(MAX_CONNS);
  localparam int CNT_W = $clog2(MAX_CONNS + 1);
  localparam int IDX_EXT_W = (IDX_W > 6) ? IDX_W : 6;

  typedef enum logic [2:0] {
    ST_SYN_SENT    = 3'd0,
    ST_SYN_RCVD    = 3'd1,
    ST_ESTABLISHED = 3'd2,
    ST_FIN_WAIT_1  = 3'd3,
    ST_FIN_WAIT_2  = 3'd4,
    ST_TIME_WAIT   = 3'd5,
    ST_CLOSED      = 3'd6,
    ST_RESET       = 3'd7
  } conn_status_t;

  typedef enum logic [2:0] {
    OUT_NEW     = 3'd0,
    OUT_SAME    = 3'd1,
    OUT_CHANGED = 3'd2,
    OUT_NOMATCH = 3'd3,
    OUT_FULL    = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_MATCH,
    FSM_APPLY
  } fsm_state_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic apply;
  } tct_cmd_t;
endpackage
`default_nettype wire

// ----- sv/tct_if.sv -----
// Handshake interfaces for header transactions and result transactions.
`timescale 1ns / 1ps
`default_nettype none
interface tct_hdr_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [31:0] seq_num;
  logic        flag_syn;
  logic        flag_ack;
  logic        flag_fin;
  logic        flag_rst;
  modport source (output valid, src_ip, dst_ip, src_port, dst_port, seq_num,
                  flag_syn, flag_ack, flag_fin, flag_rst, input ready);
  modport sink (input valid, src_ip, dst_ip, src_port, dst_port, seq_num,
                flag_syn, flag_ack, flag_fin, flag_rst, output ready);
endinterface

interface tct_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] outcome;
  logic [5:0] entry_index;
  logic       sender_side;
  logic [2:0] conn_status;
  modport source (output valid, outcome, entry_index, sender_side, conn_status,
                  input ready);
  modport sink (input valid, outcome, entry_index, sender_side, conn_status,
                output ready);
endinterface
`default_nettype wire

// ----- sv/tct_ctrl.sv -----
// Controller state machine of the connection tracker.
`timescale 1ns / 1ps
`default_nettype none
`include "tcp_connection_tracker_top_defines.svh"
module tct_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tct_pkg::tct_cmd_t  cmd
);
  import tct_pkg::*;

  fsm_state_t state, state_next;
  logic out_valid_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE:  if (in_valid) state_next = FSM_MATCH;
      FSM_MATCH: state_next = FSM_APPLY;
      FSM_APPLY: if (out_free) state_next = FSM_IDLE;
      default:   state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      FSM_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      FSM_MATCH: cmd.match = 1'b1;
      FSM_APPLY: cmd.apply = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.apply) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `TCT_ASSERT_NEXT(a_capture_then_match, cmd.capture, state == FSM_MATCH)
  `TCT_ASSERT_NEXT(a_apply_sets_valid, cmd.apply, out_valid)
  `TCT_ASSERT_NOW(a_apply_needs_room, cmd.apply, !out_valid || out_ready)
endmodule
`default_nettype wire

// ----- sv/tct_dp.sv -----
// Datapath of the connection tracker: entry cells, tuple match and update.
`timescale 1ns / 1ps
`default_nettype none
module tct_dp (
  input  wire logic         clk,
  input  wire logic         rst,
  input  tct_pkg::tct_cmd_t cmd,
  input  wire logic [31:0]  src_ip,
  input  wire logic [31:0]  dst_ip,
  input  wire logic [15:0]  src_port,
  input  wire logic [15:0]  dst_port,
  input  wire logic [31:0]  seq_num,
  input  wire logic         flag_syn,
  input  wire logic         flag_ack,
  input  wire logic         flag_fin,
  input  wire logic         flag_rst,
  output logic [2:0]        outcome,
  output logic [5:0]        entry_index,
  output logic              sender_side,
  output logic [2:0]        conn_status
);
  import tct_pkg::*;

  // Captured header.
  logic [31:0] h_sip, h_dip, h_seq;
  logic [15:0] h_sport, h_dport;
  logic h_syn, h_ack, h_fin, h_rst;

  // Entry cells.
  logic [31:0]  c_ip   [MAX_CONNS];
  logic [31:0]  s_ip   [MAX_CONNS];
  logic [15:0]  c_pt   [MAX_CONNS];
  logic [15:0]  s_pt   [MAX_CONNS];
  logic [31:0]  nseq   [MAX_CONNS];
  conn_status_t stat   [MAX_CONNS];
  logic         closer [MAX_CONNS];
  logic [CNT_W-1:0] used;

  // Registered match vectors.
  logic [MAX_CONNS-1:0] hit, rev;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      h_sip <= src_ip;  h_dip <= dst_ip;
      h_sport <= src_port;  h_dport <= dst_port;
      h_seq <= seq_num;
      h_syn <= flag_syn;  h_ack <= flag_ack;
      h_fin <= flag_fin;  h_rst <= flag_rst;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int i = 0; i < MAX_CONNS; i++) begin
        logic fwd, bwd, live;
        live = (CNT_W'(i) < used);
        fwd = c_ip[i] == h_sip && s_ip[i] == h_dip &&
              c_pt[i] == h_sport && s_pt[i] == h_dport;
        bwd = c_ip[i] == h_dip && s_ip[i] == h_sip &&
              c_pt[i] == h_dport && s_pt[i] == h_sport;
        hit[i] <= live && (fwd || bwd);
        rev[i] <= !fwd;
      end
    end
  end

  // First hit in allocation order, as a one-hot vector.
  logic [MAX_CONNS-1:0] sel;
  logic [IDX_W-1:0]     sel_idx;
  logic                 found, side, sel_closer;
  conn_status_t         sel_stat, next_stat;
  logic [31:0]          sel_nseq;
  logic                 fired, is_new, full;

  assign sel = hit & (~hit + MAX_CONNS'(1));
  assign found = |hit;
  assign is_new = h_syn && !h_ack;
  assign full = (used == CNT_W'(MAX_CONNS));

  always_comb begin
    sel_idx = '0;
    side = 1'b0;
    sel_closer = 1'b0;
    sel_stat = ST_SYN_SENT;
    sel_nseq = '0;
    for (int i = 0; i < MAX_CONNS; i++) begin
      if (sel[i]) begin
        sel_idx = sel_idx | IDX_W'(i);
        side = rev[i];
        sel_closer = closer[i];
        sel_stat = stat[i];
        sel_nseq = nseq[i];
      end
    end
  end

  always_comb begin
    fired = 1'b1;
    next_stat = sel_stat;
    if (h_syn && h_ack && side && sel_stat == ST_SYN_SENT) begin
      next_stat = ST_SYN_RCVD;
    end else if (!h_syn && h_ack && !side && sel_stat == ST_SYN_RCVD &&
                 sel_nseq == h_seq) begin
      next_stat = ST_ESTABLISHED;
    end else if (h_fin && sel_stat == ST_ESTABLISHED) begin
      next_stat = ST_FIN_WAIT_1;
    end else if (h_ack && !h_fin && sel_stat == ST_FIN_WAIT_1 && sel_closer != side) begin
      next_stat = ST_FIN_WAIT_2;
    end else if (h_ack && h_fin && (sel_stat == ST_FIN_WAIT_2 ||
                 sel_stat == ST_FIN_WAIT_1) && sel_closer != side) begin
      next_stat = ST_TIME_WAIT;
    end else if (h_ack && !h_fin && sel_stat == ST_TIME_WAIT && sel_closer == side) begin
      next_stat = ST_CLOSED;
    end else if (h_rst) begin
      next_stat = ST_RESET;
    end else begin
      fired = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.apply && is_new && !full) begin
      used <= used + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int i = 0; i < MAX_CONNS; i++) begin
        if (is_new) begin
          if (!full && used == CNT_W'(i)) begin
            c_ip[i] <= h_sip;  s_ip[i] <= h_dip;
            c_pt[i] <= h_sport;  s_pt[i] <= h_dport;
            nseq[i] <= h_seq + 32'd1;
            stat[i] <= ST_SYN_SENT;
            closer[i] <= 1'b0;
          end
        end else if (found && sel[i]) begin
          stat[i] <= next_stat;
          if (h_fin && sel_stat == ST_ESTABLISHED && fired &&
              next_stat == ST_FIN_WAIT_1) begin
            closer[i] <= side;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      outcome <= OUT_NOMATCH;
      entry_index <= '0;
      sender_side <= 1'b0;
      conn_status <= ST_SYN_SENT;
      if (is_new) begin
        if (full) begin
          outcome <= OUT_FULL;
        end else begin
          outcome <= OUT_NEW;
          entry_index <= 6'(IDX_EXT_W'(used[IDX_W-1:0]));
        end
      end else if (found) begin
        outcome <= fired ? OUT_CHANGED : OUT_SAME;
        entry_index <= 6'(IDX_EXT_W'(sel_idx));
        sender_side <= side;
        conn_status <= next_stat;
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/tcp_connection_tracker_top.sv -----
// Top level of the TCP connection tracker.
`timescale 1ns / 1ps
`default_nettype none
// The tracker takes one TCP/IP header per transaction on hdr and returns one
// result transaction on res. A SYN without ACK claims the next free entry of a
// table of MAX_CONNS connections; every other header is matched against the
// claimed entries in allocation order, in either direction, and the first hit
// steps through the handshake, closing and reset states. Each header passes
// through capture, match and apply in order: the accepting edge captures it,
// the match state registers the parallel tuple compare over all entry cells,
// and the apply state does the priority pick, the update of the chosen entry
// and the load of the result register. The next header is accepted only once
// the previous one has left the apply state; a result that waits in the output
// register does not block the capture of the next header, only its final
// update step. No clearing pass is needed after reset: entries at or above
// the claim count are never considered.
module tcp_connection_tracker_top (
  input wire logic clk,
  input wire logic rst,
  tct_hdr_if.sink  hdr,
  tct_res_if.source res
);
  import tct_pkg::*;

  tct_cmd_t cmd;

  // The controller sequences capture, match and update, and owns the
  // result valid flag.
  tct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hdr.valid),
    .in_ready  (hdr.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .cmd       (cmd)
  );

  // The datapath holds the entry cells and the result register.
  tct_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .src_ip      (hdr.src_ip),
    .dst_ip      (hdr.dst_ip),
    .src_port    (hdr.src_port),
    .dst_port    (hdr.dst_port),
    .seq_num     (hdr.seq_num),
    .flag_syn    (hdr.flag_syn),
    .flag_ack    (hdr.flag_ack),
    .flag_fin    (hdr.flag_fin),
    .flag_rst    (hdr.flag_rst),
    .outcome     (res.outcome),
    .entry_index (res.entry_index),
    .sender_side (res.sender_side),
    .conn_status (res.conn_status)
  );
endmodule
`default_nettype wire
